FILE: hw/rtl/mrsp_pkg.sv
// Shared types and constants of the MIDI running-status parser.
package mrsp_pkg;

    localparam int POS_W = 9;

    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_STOP   = 8'hF7;
    localparam logic [2:0] ONE_DATA_TOP = 3'b110;

    localparam logic       KIND_SHORT = 1'b0;
    localparam logic       KIND_SYSEX = 1'b1;

    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [7:0]       status_byte;
        logic [7:0]       first_data;
        logic [7:0]       second_data;
        logic [1:0]       message_length;
        logic [7:0]       sysex_data;
        logic [POS_W-1:0] sysex_position;
        logic             sysex_end;
        logic             sysex_overflow;
    } res_t;

endpackage

FILE: hw/rtl/midi_running_status_parser.sv
// Top level of the MIDI byte-stream parser with running status and sysex streaming.
//
// Input channel (s_): one MIDI byte per beat. Result channel (m_): one beat per
// completed channel message (kind 0) or per streamed sysex byte (kind 1).
// Channel status bytes set running status; program change and channel pressure
// complete after one data byte, all others after two. Sysex bytes are numbered
// from 0; bytes past SYSEX_MAX-2 are dropped and flagged on the closing 0xF7.
// Bytes that complete nothing give no result beat.
// Throughput: one input beat per cycle while s_ready is high.
// The decode is a single registered pass.
// The result register has a skid entry behind it, so s_ready stays high while
// one result waits; s_ready drops only when both entries are full, and rises
// again the cycle after the receiver takes a beat.
// Reset (aresetn low, synchronous): mode idle, no running status, no result
// beats held; data bytes are ignored until a channel status or 0xF0 arrives.
module midi_running_status_parser #(
    parameter int SYSEX_MAX = 512
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_midi_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kind,
    output logic [7:0]                   m_status_byte,
    output logic [7:0]                   m_first_data,
    output logic [7:0]                   m_second_data,
    output logic [1:0]                   m_message_length,
    output logic [7:0]                   m_sysex_data,
    output logic [mrsp_pkg::POS_W-1:0]   m_sysex_position,
    output logic                         m_sysex_end,
    output logic                         m_sysex_overflow
);

    logic           in_fire;
    logic           res_valid;
    mrsp_pkg::res_t res;
    mrsp_pkg::res_t out_res;

    assign in_fire = s_valid && s_ready;

    mrsp_parser #(
        .SYSEX_MAX(SYSEX_MAX)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_midi_byte),
        .res_valid(res_valid),
        .res      (res)
    );

    mrsp_out_skid u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (in_fire && res_valid),
        .push_res(res),
        .can_push(s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (out_res)
    );

    assign m_kind           = out_res.kind;
    assign m_status_byte    = out_res.status_byte;
    assign m_first_data     = out_res.first_data;
    assign m_second_data    = out_res.second_data;
    assign m_message_length = out_res.message_length;
    assign m_sysex_data     = out_res.sysex_data;
    assign m_sysex_position = out_res.sysex_position;
    assign m_sysex_end      = out_res.sysex_end;
    assign m_sysex_overflow = out_res.sysex_overflow;

endmodule

FILE: hw/rtl/mrsp_parser.sv
// Byte decoder with running status, sysex counter and result formation.
module mrsp_parser #(
    parameter int SYSEX_MAX = 512
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic [7:0]     in_byte,
    output logic           res_valid,
    output mrsp_pkg::res_t res
);

    localparam int CW = $clog2(SYSEX_MAX + 1);
    localparam logic [CW:0] MaxW = (CW+1)'(SYSEX_MAX);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_DATA1 = 2'd1,
        MODE_DATA2 = 2'd2,
        MODE_SYSEX = 2'd3
    } mode_t;

    mode_t         mode_reg, mode_next;
    logic [7:0]    status_reg, status_next;
    logic [7:0]    held_reg, held_next;
    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;

    logic [CW:0]   count_inc;
    logic [CW+8:0] pos_ext;

    assign count_inc = {1'b0, count_reg} + (CW+1)'(1);
    assign pos_ext   = (CW+9)'(count_reg);

    always_comb begin
        mode_next    = mode_reg;
        status_next  = status_reg;
        held_next    = held_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (in_byte[7]) begin
            if (in_byte < mrsp_pkg::SYSEX_START) begin
                status_next = in_byte;
                mode_next   = MODE_DATA1;
            end else if (in_byte == mrsp_pkg::SYSEX_START) begin
                mode_next          = MODE_SYSEX;
                dropped_next       = 1'b0;
                count_next         = CW'(1);
                res_valid          = 1'b1;
                res.kind           = mrsp_pkg::KIND_SYSEX;
                res.sysex_data     = in_byte;
            end else if (in_byte == mrsp_pkg::SYSEX_STOP && mode_reg == MODE_SYSEX) begin
                res_valid          = 1'b1;
                res.kind           = mrsp_pkg::KIND_SYSEX;
                res.sysex_data     = in_byte;
                res.sysex_position = pos_ext[mrsp_pkg::POS_W-1:0];
                res.sysex_end      = 1'b1;
                res.sysex_overflow = dropped_reg;
                if ({1'b0, count_reg} < MaxW) begin
                    count_next = count_inc[CW-1:0];
                end
                mode_next = MODE_IDLE;
            end
        end else begin
            case (mode_reg)
                MODE_DATA1: begin
                    if (status_reg[7:5] == mrsp_pkg::ONE_DATA_TOP) begin
                        res_valid          = 1'b1;
                        res.kind           = mrsp_pkg::KIND_SHORT;
                        res.status_byte    = status_reg;
                        res.first_data     = in_byte;
                        res.message_length = mrsp_pkg::LEN_TWO;
                    end else begin
                        held_next = in_byte;
                        mode_next = MODE_DATA2;
                    end
                end
                MODE_DATA2: begin
                    res_valid          = 1'b1;
                    res.kind           = mrsp_pkg::KIND_SHORT;
                    res.status_byte    = status_reg;
                    res.first_data     = held_reg;
                    res.second_data    = in_byte;
                    res.message_length = mrsp_pkg::LEN_THREE;
                    mode_next          = MODE_DATA1;
                end
                MODE_SYSEX: begin
                    if (count_inc < MaxW) begin
                        res_valid          = 1'b1;
                        res.kind           = mrsp_pkg::KIND_SYSEX;
                        res.sysex_data     = in_byte;
                        res.sysex_position = pos_ext[mrsp_pkg::POS_W-1:0];
                        count_next         = count_inc[CW-1:0];
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            status_reg  <= '0;
            held_reg    <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else if (in_fire) begin
            mode_reg    <= mode_next;
            status_reg  <= status_next;
            held_reg    <= held_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    a_sysex_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SYSEX |-> count_reg != '0 && {1'b0, count_reg} < MaxW)
        else $error("sysex count out of range");

    a_short_needs_status: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_DATA1 || mode_reg == MODE_DATA2 |-> status_reg[7])
        else $error("data mode without running status");

    a_drop_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && mode_reg == MODE_SYSEX && !in_byte[7] && !res_valid
        |=> dropped_reg && $stable(count_reg))
        else $error("sysex byte lost below capacity");

endmodule

FILE: hw/rtl/mrsp_out_skid.sv
// Result register with one skid entry between parser and result channel.
module mrsp_out_skid (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mrsp_pkg::res_t push_res,
    output logic           can_push,
    output logic           m_valid,
    input  logic           m_ready,
    output mrsp_pkg::res_t m_res
);

    logic           main_valid_reg;
    logic           skid_valid_reg;
    mrsp_pkg::res_t main_reg;
    mrsp_pkg::res_t skid_reg;
    logic           out_fire;

    assign out_fire = main_valid_reg && m_ready;
    assign can_push = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_res    = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire || !main_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || out_fire) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire || !main_valid_reg) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (!main_valid_reg || out_fire) begin
                main_reg <= push_res;
            end else begin
                skid_reg <= push_res;
            end
        end
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry without result beat");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("push into full skid");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_fire |=> main_valid_reg && !skid_valid_reg)
        else $error("skid entry not advanced");

endmodule

FILE: tb/sv/midi_running_status_checker.sv
// Checker for the MIDI running-status parser: predicts result beats and compares them.
module midi_running_status_checker #(
    parameter int SYSEX_MAX = 512
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [7:0]                 s_midi_byte,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_kind,
    input  logic [7:0]                 m_status_byte,
    input  logic [7:0]                 m_first_data,
    input  logic [7:0]                 m_second_data,
    input  logic [1:0]                 m_message_length,
    input  logic [7:0]                 m_sysex_data,
    input  logic [mrsp_pkg::POS_W-1:0] m_sysex_position,
    input  logic                       m_sysex_end,
    input  logic                       m_sysex_overflow,
    output int                         errors,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_FIRST,
        RX_SECOND,
        RX_SYSEX
    } rx_mode_t;

    rx_mode_t       rx_mode;
    logic [7:0]     run_status;
    logic [7:0]     held_data;
    int             sx_count;
    logic           sx_dropped;
    mrsp_pkg::res_t parsed_q[$];
    int             err_cnt;

    task automatic decode_byte(input logic [7:0] b, output logic hit,
                               output mrsp_pkg::res_t r);
        r   = '0;
        hit = 1'b0;
        if (b[7]) begin
            if (b < mrsp_pkg::SYSEX_START) begin
                run_status = b;
                rx_mode    = RX_FIRST;
            end else if (b == mrsp_pkg::SYSEX_START) begin
                rx_mode        = RX_SYSEX;
                sx_dropped     = 1'b0;
                r.kind         = mrsp_pkg::KIND_SYSEX;
                r.sysex_data   = b;
                hit            = 1'b1;
                sx_count       = 1;
            end else if (b == mrsp_pkg::SYSEX_STOP && rx_mode == RX_SYSEX) begin
                r.kind           = mrsp_pkg::KIND_SYSEX;
                r.sysex_data     = b;
                r.sysex_position = sx_count[mrsp_pkg::POS_W-1:0];
                r.sysex_end      = 1'b1;
                r.sysex_overflow = sx_dropped;
                hit              = 1'b1;
                if (sx_count < SYSEX_MAX) sx_count++;
                rx_mode = RX_IDLE;
            end
        end else begin
            case (rx_mode)
                RX_FIRST: begin
                    if (run_status[7:5] == mrsp_pkg::ONE_DATA_TOP) begin
                        r.kind           = mrsp_pkg::KIND_SHORT;
                        r.status_byte    = run_status;
                        r.first_data     = b;
                        r.message_length = mrsp_pkg::LEN_TWO;
                        hit              = 1'b1;
                    end else begin
                        held_data = b;
                        rx_mode   = RX_SECOND;
                    end
                end
                RX_SECOND: begin
                    r.kind           = mrsp_pkg::KIND_SHORT;
                    r.status_byte    = run_status;
                    r.first_data     = held_data;
                    r.second_data    = b;
                    r.message_length = mrsp_pkg::LEN_THREE;
                    hit              = 1'b1;
                    rx_mode          = RX_FIRST;
                end
                RX_SYSEX: begin
                    if (sx_count + 1 < SYSEX_MAX) begin
                        r.kind           = mrsp_pkg::KIND_SYSEX;
                        r.sysex_data     = b;
                        r.sysex_position = sx_count[mrsp_pkg::POS_W-1:0];
                        hit              = 1'b1;
                        sx_count++;
                    end else begin
                        sx_dropped = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : track
        logic           hit;
        mrsp_pkg::res_t want;
        mrsp_pkg::res_t got;
        if (!aresetn) begin
            rx_mode    = RX_IDLE;
            run_status = '0;
            held_data  = '0;
            sx_count   = 0;
            sx_dropped = 1'b0;
            parsed_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_midi_byte, hit, want);
                if (hit) parsed_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.kind           = m_kind;
                got.status_byte    = m_status_byte;
                got.first_data     = m_first_data;
                got.second_data    = m_second_data;
                got.message_length = m_message_length;
                got.sysex_data     = m_sysex_data;
                got.sysex_position = m_sysex_position;
                got.sysex_end      = m_sysex_end;
                got.sysex_overflow = m_sysex_overflow;
                if (parsed_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: result beat with nothing expected, expected none, got %h",
                             $time, got);
                end else begin
                    want = parsed_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("status_byte", 32'(want.status_byte),
                                32'(got.status_byte));
                    check_field("first_data", 32'(want.first_data),
                                32'(got.first_data));
                    check_field("second_data", 32'(want.second_data),
                                32'(got.second_data));
                    check_field("message_length", 32'(want.message_length),
                                32'(got.message_length));
                    check_field("sysex_data", 32'(want.sysex_data),
                                32'(got.sysex_data));
                    check_field("sysex_position", 32'(want.sysex_position),
                                32'(got.sysex_position));
                    check_field("sysex_end", 32'(want.sysex_end),
                                32'(got.sysex_end));
                    check_field("sysex_overflow", 32'(want.sysex_overflow),
                                32'(got.sysex_overflow));
                end
            end
        end
        pending <= parsed_q.size();
        errors  <= err_cnt;
    end

endmodule

FILE: tb/sv/tb_midi_running_status_parser.sv
// Testbench top for the MIDI running-status parser: stimulus, receiver stalls and verdict.
module tb_midi_running_status_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SYSEX_CAP = 512;
    localparam int ITEMS     = 1150;
    localparam logic [7:0] OPENING [25] = '{
        8'h45, 8'hF7, 8'h90, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'hC5, 8'h7F, 8'h00,
        8'hDF, 8'hF8, 8'h55, 8'hF0, 8'h01, 8'hFF, 8'hF0, 8'h02, 8'hF7, 8'h05,
        8'hF0, 8'h11, 8'hEF, 8'h7F, 8'h00
    };

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_valid     = 1'b0;
    logic [7:0]                     s_midi_byte = 8'h00;
    logic                           m_ready     = 1'b0;
    logic                           s_ready;
    logic                           m_valid;
    logic                           m_kind;
    logic [7:0]                     m_status_byte;
    logic [7:0]                     m_first_data;
    logic [7:0]                     m_second_data;
    logic [1:0]                     m_message_length;
    logic [7:0]                     m_sysex_data;
    logic [mrsp_pkg::POS_W-1:0]     m_sysex_position;
    logic                           m_sysex_end;
    logic                           m_sysex_overflow;
    int                             errors;
    int                             pending;

    bit tx_burst  = 1'b0;
    bit rx_free   = 1'b0;
    int hold_req  = 0;
    int hold_done = 0;
    int counted   = 0;

    always #5ns aclk = ~aclk;

    midi_running_status_parser #(
        .SYSEX_MAX(SYSEX_CAP)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_midi_byte     (s_midi_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_status_byte   (m_status_byte),
        .m_first_data    (m_first_data),
        .m_second_data   (m_second_data),
        .m_message_length(m_message_length),
        .m_sysex_data    (m_sysex_data),
        .m_sysex_position(m_sysex_position),
        .m_sysex_end     (m_sysex_end),
        .m_sysex_overflow(m_sysex_overflow)
    );

    midi_running_status_checker #(
        .SYSEX_MAX(SYSEX_CAP)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_midi_byte     (s_midi_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_status_byte   (m_status_byte),
        .m_first_data    (m_first_data),
        .m_second_data   (m_second_data),
        .m_message_length(m_message_length),
        .m_sysex_data    (m_sysex_data),
        .m_sysex_position(m_sysex_position),
        .m_sysex_end     (m_sysex_end),
        .m_sysex_overflow(m_sysex_overflow),
        .errors          (errors),
        .pending         (pending)
    );

    function automatic int idle_len(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] system_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(8'hF1, 8'hFF)); while (b == mrsp_pkg::SYSEX_STOP);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : idle_len(55);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_midi_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (b < 8'hF1 || b == mrsp_pkg::SYSEX_STOP) counted++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic send_data(input int noise_pct);
        if ($urandom_range(0, 99) < noise_pct) send_byte(system_byte());
        send_byte(8'($urandom_range(0, 127)));
    endtask

    task automatic send_channel_msg();
        logic [7:0] status;
        int         reps;
        status = 8'($urandom_range(8'h80, 8'hEF));
        reps   = $urandom_range(1, 4);
        send_byte(status);
        for (int i = 0; i < reps; i++) begin
            send_data(5);
            if (status[7:5] != mrsp_pkg::ONE_DATA_TOP) begin
                if ($urandom_range(0, 19) == 0) return;
                send_data(5);
            end
        end
    endtask

    task automatic send_sysex(input int n_data, input bit close);
        send_byte(mrsp_pkg::SYSEX_START);
        for (int i = 0; i < n_data; i++) begin
            if (n_data < 64 && $urandom_range(0, 49) == 0) send_byte(mrsp_pkg::SYSEX_START);
            send_data(n_data < 64 ? 3 : 0);
        end
        if (close) send_byte(mrsp_pkg::SYSEX_STOP);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_done != hold_req) begin
                hold_done = hold_req;
                m_ready <= 1'b0;
                repeat (80) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!aresetn) begin
                m_ready <= 1'b0;
            end else begin : rx_pace
                int stall;
                stall = (!rx_free && $urandom_range(0, 99) < 25) ? idle_len(0) : 0;
                m_ready <= 1'b1;
                if (stall > 0) begin
                    @(posedge aclk);
                    m_ready <= 1'b0;
                    repeat (stall - 1) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int  r;
        bit  pressed;
        pressed = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (OPENING[i]) send_byte(OPENING[i]);
        drain();

        // fill the sysex store exactly, then overflow by one byte
        tx_burst = 1'b1;
        send_sysex(SYSEX_CAP - 1, 1'b1);
        tx_burst = 1'b0;
        drain();

        while (counted < ITEMS) begin
            if ($urandom_range(0, 9) == 0) tx_burst = ~tx_burst;
            if ($urandom_range(0, 9) == 0) rx_free = ~rx_free;
            if (!pressed && counted > 800) begin
                pressed  = 1'b1;
                hold_req++;
                tx_burst = 1'b1;
                send_byte(8'hC3);
                repeat (30) send_byte(8'($urandom_range(0, 127)));
                tx_burst = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_channel_msg();
            end else if (r < 80) begin
                send_sysex($urandom_range(0, 12), $urandom_range(0, 99) < 85);
            end else if (r < 90) begin
                send_byte($urandom_range(0, 1) ? mrsp_pkg::SYSEX_STOP : system_byte());
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
